[rtl/zdt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zdt_pkg: shared types and constants of the track zone dwell table
// Holds the table size, the beat formats of both channels, the slot record
// and the lookup outcome struct that passes from the lookup to the dwell unit.
// ----------------------------------------------------------------------------
package zdt_pkg;

	// Table geometry.
	localparam int SLOTS = 64;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	// Field widths.
	localparam int ID_W      = 32;
	localparam int TIME_W    = 48;
	localparam int REGION_W  = 8;
	localparam int HITS_W    = 20;
	localparam int ZONE_W    = 17;
	localparam int MS_PER_S_W = 10;
	localparam int LOITER_MS_W = ZONE_W + MS_PER_S_W;

	// Constants.
	localparam logic [HITS_W-1:0]     HITS_MAX = HITS_W'(1000000);
	localparam logic [MS_PER_S_W-1:0] MS_PER_S = MS_PER_S_W'(1000);

	// Item modes.
	localparam logic MODE_OBSERVE = 1'b0;
	localparam logic MODE_FORGET  = 1'b1;

	// Input beat.
	typedef struct packed {
		logic                mode;
		logic [ID_W-1:0]     obj_id;
		logic [TIME_W-1:0]   time_ms;
		logic [REGION_W-1:0] region;
		logic                zone_known;
		logic [ZONE_W-1:0]   zone_inertia;
		logic [ZONE_W-1:0]   zone_loiter_seconds;
	} item_t;

	// Result beat.
	typedef struct packed {
		logic [REGION_W-1:0] hit_region;
		logic                settled;
		logic                loitering;
		logic [TIME_W-1:0]   since_ms;
	} result_t;

	// One slot of the dwell store.
	typedef struct packed {
		logic [REGION_W-1:0] region;
		logic [HITS_W-1:0]   hits;
		logic [TIME_W-1:0]   since;
	} slot_t;

	// Outcome of a table lookup.
	typedef struct packed {
		logic             found;
		logic             claimed;
		logic             full;
		logic [IDX_W-1:0] idx;
	} look_res_t;

endpackage

[rtl/zdt_lookup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zdt_lookup: track id search and slot allocation
// Scans the track id memory one entry per cycle, finds the slot of an id and
// the first free slot, then claims or frees a slot in its commit state.
// ----------------------------------------------------------------------------
module zdt_lookup (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    go,
	input  logic                    mode,
	input  logic [zdt_pkg::ID_W-1:0] obj_id,
	output logic                    done,
	output zdt_pkg::look_res_t      res
);

	typedef enum logic [2:0] {
		L_IDLE   = 3'b001,
		L_SCAN   = 3'b010,
		L_COMMIT = 3'b100
	} look_state_t;

	look_state_t state_q, state_d;

	logic [zdt_pkg::ID_W-1:0]  track_mem [zdt_pkg::SLOTS];
	logic [zdt_pkg::SLOTS-1:0] used_q;

	logic [zdt_pkg::CNT_W-1:0] rd_cnt_q;
	logic                      rd_en;
	logic [zdt_pkg::ID_W-1:0]  rd_data_s1;
	logic                      cmp_vld_s1;
	logic [zdt_pkg::IDX_W-1:0] cmp_idx_s1;

	logic                      found_q;
	logic [zdt_pkg::IDX_W-1:0] hit_idx_q;
	logic                      free_q;
	logic [zdt_pkg::IDX_W-1:0] free_idx_q;

	logic cmp_hit;
	logic cmp_free;
	logic scan_last;
	logic claim_en;
	logic forget_en;

	logic               done_q;
	zdt_pkg::look_res_t res_q;

	// Read one entry per scan cycle; the id is compared in the cycle after its read.
	assign rd_en = (state_q == L_SCAN) && (rd_cnt_q != zdt_pkg::CNT_W'(zdt_pkg::SLOTS));

	assign cmp_hit   = cmp_vld_s1 && used_q[cmp_idx_s1] && (rd_data_s1 == obj_id);
	assign cmp_free  = cmp_vld_s1 && !used_q[cmp_idx_s1];
	assign scan_last = cmp_vld_s1 && (cmp_idx_s1 == zdt_pkg::IDX_W'(zdt_pkg::SLOTS - 1));

	// A new id takes the first free slot; a forget frees the slot it found.
	assign claim_en  = (state_q == L_COMMIT) && (mode == zdt_pkg::MODE_OBSERVE) &&
		!found_q && free_q;
	assign forget_en = (state_q == L_COMMIT) && (mode == zdt_pkg::MODE_FORGET) && found_q;

	// Track id memory.
	always_ff @(posedge clk) begin
		if (claim_en) begin
			track_mem[free_idx_q] <= obj_id;
		end
		if (rd_en) begin
			rd_data_s1 <= track_mem[rd_cnt_q[zdt_pkg::IDX_W-1:0]];
		end
	end

	// Slot occupancy bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			if (claim_en) begin
				used_q[free_idx_q] <= 1'b1;
			end
			if (forget_en) begin
				used_q[hit_idx_q] <= 1'b0;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			L_IDLE: begin
				if (go) begin
					state_d = L_SCAN;
				end
			end
			L_SCAN: begin
				if (scan_last) begin
					state_d = L_COMMIT;
				end
			end
			L_COMMIT: begin
				state_d = L_IDLE;
			end
			default: begin
				state_d = L_IDLE;
			end
		endcase
	end

	// Scan counter, compare stage and search results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= L_IDLE;
			rd_cnt_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
			found_q    <= 1'b0;
			free_q     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= rd_en;
			cmp_idx_s1 <= rd_cnt_q[zdt_pkg::IDX_W-1:0];
			done_q     <= (state_q == L_COMMIT);
			if ((state_q == L_IDLE) && go) begin
				rd_cnt_q <= '0;
				found_q  <= 1'b0;
				free_q   <= 1'b0;
			end else begin
				if (rd_en) begin
					rd_cnt_q <= rd_cnt_q + zdt_pkg::CNT_W'(1);
				end
				if (cmp_hit && !found_q) begin
					found_q <= 1'b1;
				end
				if (cmp_free && !free_q) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	// Slot indexes found during the scan.
	always_ff @(posedge clk) begin
		if (cmp_hit && !found_q) begin
			hit_idx_q <= cmp_idx_s1;
		end
		if (cmp_free && !free_q) begin
			free_idx_q <= cmp_idx_s1;
		end
	end

	// Lookup outcome, held until the next commit.
	always_ff @(posedge clk) begin
		if (state_q == L_COMMIT) begin
			res_q.found   <= found_q;
			res_q.claimed <= (mode == zdt_pkg::MODE_OBSERVE) && !found_q && free_q;
			res_q.full    <= (mode == zdt_pkg::MODE_OBSERVE) && !found_q && !free_q;
			res_q.idx     <= found_q ? hit_idx_q : free_idx_q;
		end
	end

	assign done = done_q;
	assign res  = res_q;

`ifndef SYNTHESIS
	// A claimed slot is marked used when the outcome is reported.
	a_claim_marks_used: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && res_q.claimed |-> used_q[res_q.idx])
		else $error("claimed slot not marked used");

	// A new search only starts from idle.
	a_go_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> (state_q == L_IDLE))
		else $error("lookup started while busy");

	// A full table and a claim exclude each other, as do a found id and a claim.
	a_claim_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(res_q.claimed && res_q.full) && !(res_q.found && res_q.claimed))
		else $error("inconsistent lookup outcome");
`endif

endmodule

[rtl/zdt_dwell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zdt_dwell: per-slot dwell record update
// Reads the slot record, restarts it on a region change, counts the hit,
// writes it back and judges the settled and loitering flags.
// ----------------------------------------------------------------------------
module zdt_dwell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             go,
	input  logic [zdt_pkg::IDX_W-1:0]        idx,
	input  logic                             claimed,
	input  zdt_pkg::item_t                   item,
	input  logic [zdt_pkg::LOITER_MS_W-1:0]  loiter_ms,
	output logic                             done,
	output zdt_pkg::result_t                 result
);

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_UPD  = 3'b010,
		D_FLAG = 3'b100
	} dwell_state_t;

	dwell_state_t state_q, state_d;

	zdt_pkg::slot_t slot_mem [zdt_pkg::SLOTS];
	zdt_pkg::slot_t rd_slot_s1;

	logic [zdt_pkg::IDX_W-1:0] idx_q;
	logic                      claimed_q;

	zdt_pkg::slot_t             old_slot;
	zdt_pkg::slot_t             new_slot;
	logic                       region_chg;
	logic [zdt_pkg::HITS_W-1:0] base_hits;

	logic [zdt_pkg::HITS_W-1:0] hits_s2;
	logic [zdt_pkg::TIME_W-1:0] since_s2;

	logic                       settled;
	logic                       loitering;
	logic [zdt_pkg::TIME_W-1:0] elapsed;

	logic             done_q;
	zdt_pkg::result_t result_q;

	// A freshly claimed slot starts from an all-zero record.
	assign old_slot   = claimed_q ? '0 : rd_slot_s1;
	assign region_chg = (old_slot.region != item.region);
	assign base_hits  = region_chg ? '0 : old_slot.hits;

	always_comb begin
		new_slot.region = item.region;
		new_slot.since  = region_chg ? item.time_ms : old_slot.since;
		if (base_hits < zdt_pkg::HITS_MAX) begin
			new_slot.hits = base_hits + zdt_pkg::HITS_W'(1);
		end else begin
			new_slot.hits = base_hits;
		end
	end

	// Slot record memory: read on start, written back in the update state.
	always_ff @(posedge clk) begin
		if ((state_q == D_IDLE) && go) begin
			rd_slot_s1 <= slot_mem[idx];
			idx_q      <= idx;
			claimed_q  <= claimed;
		end
		if (state_q == D_UPD) begin
			slot_mem[idx_q] <= new_slot;
			hits_s2         <= new_slot.hits;
			since_s2        <= new_slot.since;
		end
	end

	// Settled and loitering judgment on the updated record.
	assign elapsed = item.time_ms - since_s2;

	always_comb begin
		settled = (item.region != '0) &&
			(!item.zone_known ||
			(hits_s2 >= zdt_pkg::HITS_W'(item.zone_inertia)));
		loitering = settled && item.zone_known && (loiter_ms != '0) &&
			(item.time_ms >= since_s2) &&
			(elapsed >= zdt_pkg::TIME_W'(loiter_ms));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			D_IDLE: begin
				if (go) begin
					state_d = D_UPD;
				end
			end
			D_UPD: begin
				state_d = D_FLAG;
			end
			D_FLAG: begin
				state_d = D_IDLE;
			end
			default: begin
				state_d = D_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == D_FLAG);
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (state_q == D_FLAG) begin
			result_q.hit_region <= item.region;
			result_q.settled    <= settled;
			result_q.loitering  <= loitering;
			result_q.since_ms   <= since_s2;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[rtl/track_zone_dwell_table_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_zone_dwell_table_unit: dwell table for tracked objects in zones
//
// Usage:
//   A beat on item is taken when start is high and busy is low. busy then
//   stays high until the item is finished, and the item ports may change.
//   An observe beat gives one result beat: done is high for exactly one
//   cycle with result valid in that cycle. A forget beat gives no result.
//   The receiver cannot stall; every result must be taken when done is high.
// Operation (SLOTS = 64 slots):
//   Every item scans the whole track id memory, one entry per cycle, set by
//   its single read port. An observe item then updates its slot record and
//   shows done once the updated record is judged; the next item is accepted
//   only once the previous one has finished. A forget item, or an observe item
//   that finds the table full, frees the block once its lookup commits.
// Reset:
//   arst_n clears all slot occupancy bits at once; the block accepts an item
//   in the first cycle after reset is released.
// ----------------------------------------------------------------------------
module track_zone_dwell_table_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  zdt_pkg::item_t   item,
	output logic             done,
	output zdt_pkg::result_t result
);

	typedef enum logic [2:0] {
		T_IDLE  = 3'b001,
		T_LOOK  = 3'b010,
		T_DWELL = 3'b100
	} top_state_t;

	top_state_t state_q, state_d;

	zdt_pkg::item_t                  item_q;
	logic [zdt_pkg::LOITER_MS_W-1:0] loiter_ms_q;
	logic                            look_go_q;
	logic                            accept;

	logic               look_done;
	zdt_pkg::look_res_t look_res;
	logic               dwell_go;
	logic               dwell_done;
	zdt_pkg::result_t   dwell_result;

	logic             done_q;
	zdt_pkg::result_t result_q;
	logic             full_done;

	assign accept = start && (state_q == T_IDLE);
	assign busy   = (state_q != T_IDLE);

	// Hold the beat for the whole operation.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		loiter_ms_q <= zdt_pkg::LOITER_MS_W'(item_q.zone_loiter_seconds * zdt_pkg::MS_PER_S);
	end

	zdt_lookup u_lookup (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (look_go_q),
		.mode     (item_q.mode),
		.obj_id   (item_q.obj_id),
		.done     (look_done),
		.res      (look_res)
	);

	// An observe that owns a slot goes on to the record update.
	assign dwell_go  = (state_q == T_LOOK) && look_done &&
		(item_q.mode == zdt_pkg::MODE_OBSERVE) && !look_res.full;
	assign full_done = (state_q == T_LOOK) && look_done &&
		(item_q.mode == zdt_pkg::MODE_OBSERVE) && look_res.full;

	zdt_dwell u_dwell (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (dwell_go),
		.idx       (look_res.idx),
		.claimed   (look_res.claimed),
		.item      (item_q),
		.loiter_ms (loiter_ms_q),
		.done      (dwell_done),
		.result    (dwell_result)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			T_IDLE: begin
				if (start) begin
					state_d = T_LOOK;
				end
			end
			T_LOOK: begin
				if (look_done) begin
					state_d = dwell_go ? T_DWELL : T_IDLE;
				end
			end
			T_DWELL: begin
				if (dwell_done) begin
					state_d = T_IDLE;
				end
			end
			default: begin
				state_d = T_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= T_IDLE;
			look_go_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			look_go_q <= accept;
			done_q    <= full_done || ((state_q == T_DWELL) && dwell_done);
		end
	end

	// Output register; a full table reports the raw region.
	always_ff @(posedge clk) begin
		if (full_done) begin
			result_q.hit_region <= item_q.region;
			result_q.settled    <= (item_q.region != '0);
			result_q.loitering  <= 1'b0;
			result_q.since_ms   <= item_q.time_ms;
		end else if ((state_q == T_DWELL) && dwell_done) begin
			result_q <= dwell_result;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	// A result only follows work in progress.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q != T_IDLE))
		else $error("result without an item in progress");

	// A forget or a full-table lookup never reaches the record update.
	a_no_dwell_on_forget: assert property (@(posedge clk) disable iff (!arst_n)
		dwell_go |-> (item_q.mode == zdt_pkg::MODE_OBSERVE) && !look_res.full)
		else $error("record update started for forget or full table");

	// An accepted beat starts a lookup in the next cycle.
	a_accept_starts_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> look_go_q && (state_q == T_LOOK))
		else $error("accepted beat did not start a lookup");
`endif

endmodule
